// File: rtl/cau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cau_pkg;

  localparam int WordBits = 32;
  localparam int FracBits = 16;

  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;

  localparam logic [1:0] REL_LESS    = 2'd0;
  localparam logic [1:0] REL_EQUAL   = 2'd1;
  localparam logic [1:0] REL_GREATER = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SAT    = 2'd1;
  localparam logic [1:0] ST_DIVZ   = 2'd2;

  // Per-item control that travels with the operands down the pipeline
  typedef struct packed {
    logic [2:0] cmd;
    logic [1:0] relation;
    logic       divz;
  } cau_ctl_t;

endpackage
`default_nettype wire

// File: rtl/cau_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Stage 1: operand sums or differences, products and squared magnitudes. Stage 2: combine sums, relation,
// division numerators and divisor.
module cau_front
  import cau_pkg::*;
#(
  parameter int WORD_BITS = WordBits,
  parameter int FRAC_BITS = FracBits,
  localparam int PW = 2 * WORD_BITS + 2,
  localparam int NW = PW + FRAC_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [2:0]                  in_cmd,
  input  wire logic signed [WORD_BITS-1:0] in_a_re,
  input  wire logic signed [WORD_BITS-1:0] in_a_im,
  input  wire logic signed [WORD_BITS-1:0] in_b_re,
  input  wire logic signed [WORD_BITS-1:0] in_b_im,
  output logic                             out_valid,
  output cau_ctl_t                         out_ctl,
  output logic signed [PW-1:0]             out_x_re,
  output logic signed [PW-1:0]             out_x_im,
  output logic signed [NW-1:0]             out_n_re,
  output logic signed [NW-1:0]             out_n_im,
  output logic [PW-1:0]                    out_den
);

  localparam int MW = 2 * WORD_BITS;

  logic                 v1_r;
  logic [2:0]           cmd1_r;
  logic signed [WORD_BITS:0] sre_r, sim_r;
  logic signed [MW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic signed [MW-1:0] aa_r, ai2_r, bb_r, bi2_r;

  // Register operand sums and all products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1_r <= in_cmd;
      if (in_cmd == CMD_SUB) begin
        sre_r <= {in_a_re[WORD_BITS-1], in_a_re} - {in_b_re[WORD_BITS-1], in_b_re};
        sim_r <= {in_a_im[WORD_BITS-1], in_a_im} - {in_b_im[WORD_BITS-1], in_b_im};
      end else begin
        sre_r <= {in_a_re[WORD_BITS-1], in_a_re} + {in_b_re[WORD_BITS-1], in_b_re};
        sim_r <= {in_a_im[WORD_BITS-1], in_a_im} + {in_b_im[WORD_BITS-1], in_b_im};
      end
      p_rr_r <= MW'(in_a_re * in_b_re);
      p_ii_r <= MW'(in_a_im * in_b_im);
      p_ri_r <= MW'(in_a_re * in_b_im);
      p_ir_r <= MW'(in_a_im * in_b_re);
      aa_r   <= MW'(in_a_re * in_a_re);
      ai2_r  <= MW'(in_a_im * in_a_im);
      bb_r   <= MW'(in_b_re * in_b_re);
      bi2_r  <= MW'(in_b_im * in_b_im);
    end
  end

  logic [PW-1:0] ma, mb;
  logic signed [PW-1:0] dot, crs;
  logic [1:0] rel;

  always_comb begin
    ma  = PW'(unsigned'(aa_r)) + PW'(unsigned'(ai2_r));
    mb  = PW'(unsigned'(bb_r)) + PW'(unsigned'(bi2_r));
    dot = PW'(p_rr_r) + PW'(p_ii_r);
    crs = PW'(p_ir_r) - PW'(p_ri_r);
    if (ma < mb) rel = REL_LESS;
    else if (ma == mb) rel = REL_EQUAL;
    else rel = REL_GREATER;
  end

  // Register combined terms for the output stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctl.cmd      <= cmd1_r;
      out_ctl.relation <= rel;
      out_ctl.divz     <= (mb == '0);
      out_den          <= mb;
      out_n_re         <= NW'(dot) <<< FRAC_BITS;
      out_n_im         <= NW'(crs) <<< FRAC_BITS;
      if (cmd1_r == CMD_MUL) begin
        out_x_re <= (PW'(p_rr_r) - PW'(p_ii_r)) >>> FRAC_BITS;
        out_x_im <= (PW'(p_ri_r) + PW'(p_ir_r)) >>> FRAC_BITS;
      end else begin
        out_x_re <= PW'(sre_r);
        out_x_im <= PW'(sim_r);
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/cau_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring divider: one quotient bit per stage, sign by magnitude.
// Two divides (re and im) share the divisor.
module cau_div
  import cau_pkg::*;
#(
  parameter int NW = 82,
  parameter int DW = 66,
  parameter int XW = 66
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire cau_ctl_t             in_ctl,
  input  wire logic signed [NW-1:0] in_n_re,
  input  wire logic signed [NW-1:0] in_n_im,
  input  wire logic [DW-1:0]        in_den,
  input  wire logic signed [XW-1:0] in_x_re,
  input  wire logic signed [XW-1:0] in_x_im,
  output logic                      out_valid,
  output cau_ctl_t                  out_ctl,
  output logic signed [NW-1:0]      out_q_re,
  output logic signed [NW-1:0]      out_q_im,
  output logic signed [XW-1:0]      out_x_re,
  output logic signed [XW-1:0]      out_x_im
);

  localparam int RW = DW + 1;

  logic                 v_r   [NW+1];
  cau_ctl_t             c_r   [NW+1];
  logic [NW-1:0]        qre_r [NW+1], qim_r [NW+1];
  logic [RW-1:0]        rre_r [NW+1], rim_r [NW+1];
  logic [DW-1:0]        d_r   [NW+1];
  logic                 nre_r [NW+1], nim_r [NW+1];
  logic signed [XW-1:0] xre_r [NW+1], xim_r [NW+1];

  // Stage 0 takes magnitudes of the numerators
  always_comb begin
    v_r[0]   = in_valid;
    c_r[0]   = in_ctl;
    nre_r[0] = in_n_re[NW-1];
    nim_r[0] = in_n_im[NW-1];
    qre_r[0] = in_n_re[NW-1] ? NW'(-in_n_re) : NW'(in_n_re);
    qim_r[0] = in_n_im[NW-1] ? NW'(-in_n_im) : NW'(in_n_im);
    rre_r[0] = '0;
    rim_r[0] = '0;
    d_r[0]   = in_den;
    xre_r[0] = in_x_re;
    xim_r[0] = in_x_im;
  end

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [RW-1:0] tre, tim;
    logic [RW:0]   dre, dim;
    always_comb begin
      tre = {rre_r[s][RW-2:0], qre_r[s][NW-1]};
      tim = {rim_r[s][RW-2:0], qim_r[s][NW-1]};
      dre = {1'b0, tre} - {2'b0, d_r[s]};
      dim = {1'b0, tim} - {2'b0, d_r[s]};
    end
    // Shift in one dividend bit, subtract when it fits
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (en) begin
        v_r[s+1] <= v_r[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        c_r[s+1]   <= c_r[s];
        d_r[s+1]   <= d_r[s];
        nre_r[s+1] <= nre_r[s];
        nim_r[s+1] <= nim_r[s];
        xre_r[s+1] <= xre_r[s];
        xim_r[s+1] <= xim_r[s];
        rre_r[s+1] <= dre[RW] ? tre : dre[RW-1:0];
        rim_r[s+1] <= dim[RW] ? tim : dim[RW-1:0];
        qre_r[s+1] <= {qre_r[s][NW-2:0], ~dre[RW]};
        qim_r[s+1] <= {qim_r[s][NW-2:0], ~dim[RW]};
      end
    end
  end

  always_comb begin
    out_valid = v_r[NW];
    out_ctl   = c_r[NW];
    out_q_re  = nre_r[NW] ? -signed'(qre_r[NW]) : signed'(qre_r[NW]);
    out_q_im  = nim_r[NW] ? -signed'(qim_r[NW]) : signed'(qim_r[NW]);
    out_x_re  = xre_r[NW];
    out_x_im  = xim_r[NW];
  end

endmodule
`default_nettype wire

// File: rtl/complex_arith_unit_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Complex arithmetic unit, signed fixed point operands (Q16.16 by default).
// Input channel in_*: tdata = {b_im, b_re, a_im, a_re} (a_re in the lowest bits),
// tuser = cmd (0 add, 1 sub, 2 mul, 3 div, other codes compare only).
// Output channel out_*: tdata = {res_im, res_re}, tuser = {status, relation}.
// Every request yields exactly one result, in order.
// Throughput: one request per cycle while the output is not stalled; items are independent.
// Path: two product/combine stages, one stage per quotient bit of the restoring
// divider, one saturation stage. All commands take the same path.
// Reset (rst_n low, synchronous) empties the pipeline; no result appears
// until new requests arrive.
// When out_tready is low with a result held, the whole pipeline holds and in_tready drops; no
// request is lost or repeated. in_tready = out_tready or output empty.
module complex_arith_unit_top
  import cau_pkg::*;
#(
  parameter int WORD_BITS = WordBits,
  parameter int FRAC_BITS = FracBits
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     s_axis_in_tvalid,
  output logic                          s_axis_in_tready,
  input  wire logic [4*WORD_BITS-1:0]   s_axis_in_tdata,  // a_re, a_im, b_re, b_im
  input  wire logic [2:0]               s_axis_in_tuser,  // cmd
  output logic                          m_axis_out_tvalid,
  input  wire logic                     m_axis_out_tready,
  output logic [2*WORD_BITS-1:0]        m_axis_out_tdata, // res_re, res_im
  output logic [3:0]                    m_axis_out_tuser  // relation, status
);

  localparam int PW = 2 * WORD_BITS + 2;
  localparam int NW = PW + FRAC_BITS;
  localparam logic signed [NW-1:0] MaxV = NW'({1'b0, {(WORD_BITS-1){1'b1}}});
  localparam logic signed [NW-1:0] MinV = ~MaxV;

  logic en;
  assign en = m_axis_out_tready || !m_axis_out_tvalid;
  assign s_axis_in_tready = en;

  logic                 f_valid;
  cau_ctl_t             f_ctl;
  logic signed [PW-1:0] f_x_re, f_x_im;
  logic signed [NW-1:0] f_n_re, f_n_im;
  logic [PW-1:0]        f_den;

  cau_front #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(s_axis_in_tvalid && en),
    .in_cmd(s_axis_in_tuser),
    .in_a_re(s_axis_in_tdata[WORD_BITS-1:0]),
    .in_a_im(s_axis_in_tdata[2*WORD_BITS-1:WORD_BITS]),
    .in_b_re(s_axis_in_tdata[3*WORD_BITS-1:2*WORD_BITS]),
    .in_b_im(s_axis_in_tdata[4*WORD_BITS-1:3*WORD_BITS]),
    .out_valid(f_valid), .out_ctl(f_ctl),
    .out_x_re(f_x_re), .out_x_im(f_x_im),
    .out_n_re(f_n_re), .out_n_im(f_n_im), .out_den(f_den)
  );

  logic                 d_valid;
  cau_ctl_t             d_ctl;
  logic signed [NW-1:0] q_re, q_im;
  logic signed [PW-1:0] d_x_re, d_x_im;

  cau_div #(.NW(NW), .DW(PW), .XW(PW)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(f_valid), .in_ctl(f_ctl),
    .in_n_re(f_n_re), .in_n_im(f_n_im), .in_den(f_den),
    .in_x_re(f_x_re), .in_x_im(f_x_im),
    .out_valid(d_valid), .out_ctl(d_ctl),
    .out_q_re(q_re), .out_q_im(q_im),
    .out_x_re(d_x_re), .out_x_im(d_x_im)
  );

  // Select result, saturate, build status
  logic signed [NW-1:0]        v_re, v_im;
  logic signed [WORD_BITS-1:0] s_re, s_im;
  logic                        sat, use_val;
  logic [1:0]                  st;

  always_comb begin
    use_val = 1'b1;
    v_re = NW'(d_x_re);
    v_im = NW'(d_x_im);
    case (d_ctl.cmd)
      CMD_ADD, CMD_SUB, CMD_MUL: use_val = 1'b1;
      CMD_DIV: begin
        use_val = !d_ctl.divz;
        v_re = q_re;
        v_im = q_im;
      end
      default: use_val = 1'b0;
    endcase
    sat = 1'b0;
    if (v_re > MaxV) begin s_re = MaxV[WORD_BITS-1:0]; sat = 1'b1; end
    else if (v_re < MinV) begin s_re = MinV[WORD_BITS-1:0]; sat = 1'b1; end
    else s_re = v_re[WORD_BITS-1:0];
    if (v_im > MaxV) begin s_im = MaxV[WORD_BITS-1:0]; sat = 1'b1; end
    else if (v_im < MinV) begin s_im = MinV[WORD_BITS-1:0]; sat = 1'b1; end
    else s_im = v_im[WORD_BITS-1:0];
    if (!use_val) begin
      s_re = '0;
      s_im = '0;
      sat  = 1'b0;
    end
    if (d_ctl.cmd == CMD_DIV && d_ctl.divz) st = ST_DIVZ;
    else if (sat) st = ST_SAT;
    else st = ST_OK;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_axis_out_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_out_tvalid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_out_tdata <= {s_im, s_re};
      m_axis_out_tuser <= {st, d_ctl.relation};
    end
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    m_axis_out_tvalid && !m_axis_out_tready |=> m_axis_out_tvalid)
    else $error("result dropped under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !m_axis_out_tvalid |-> s_axis_in_tready)
    else $error("not ready with empty output");
  a_divz: assert property (@(posedge clk) disable iff (!rst_n)
    m_axis_out_tvalid && m_axis_out_tuser[3:2] == ST_DIVZ |->
    m_axis_out_tdata == '0)
    else $error("divide by zero result not zero");
`endif

endmodule
`default_nettype wire

// File: tb/complex_arith_unit_top_tb.sv
`timescale 1ns / 1ps
module complex_arith_unit_top_tb;
  import cau_pkg::*;

  localparam logic [2:0] CMD_CMP = 3'd4;
  localparam int LATENCY = 2 * WordBits + FracBits + 5;
  localparam int STALL_LIMIT = 5000;
  localparam logic signed [31:0] MAXW = 32'sh7fffffff;
  localparam logic signed [31:0] MINW = 32'sh80000000;

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic [1:0]  rel;
    logic [1:0]  st;
  } cplx_res_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [127:0] in_tdata;  // a_re, a_im, b_re, b_im
  logic [2:0] in_tuser;    // cmd
  logic out_tvalid;
  logic out_tready;
  logic [63:0] out_tdata;  // res_re, res_im
  logic [3:0] out_tuser;   // relation, status

  cplx_res_t result_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int cmd_count[8];
  int burst_left = 0;
  int idle_cycles = 0;
  int ready_mode = 0;
  int ready_left = 0;

  complex_arith_unit_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .s_axis_in_tvalid  (in_tvalid),
    .s_axis_in_tready  (in_tready),
    .s_axis_in_tdata   (in_tdata),
    .s_axis_in_tuser   (in_tuser),
    .m_axis_out_tvalid (out_tvalid),
    .m_axis_out_tready (out_tready),
    .m_axis_out_tdata  (out_tdata),
    .m_axis_out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Clamp a wide value to the signed word and flag saturation
  function automatic logic [31:0] clamp_word(input logic signed [127:0] v, inout logic sat);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = MAXW;
    lo = MINW;
    if (v > hi) begin
      sat = 1'b1;
      return MAXW;
    end
    if (v < lo) begin
      sat = 1'b1;
      return MINW;
    end
    return v[31:0];
  endfunction

  // Exact rectangular complex arithmetic at full precision
  function automatic cplx_res_t complex_result(input logic [2:0] cmd,
      input logic signed [31:0] ar, input logic signed [31:0] ai,
      input logic signed [31:0] br, input logic signed [31:0] bi);
    logic signed [127:0] xr, xi, yr, yi, ma, mb, nre, nim;
    logic sat;
    cplx_res_t r;
    xr = ar;
    xi = ai;
    yr = br;
    yi = bi;
    sat = 1'b0;
    ma = xr * xr + xi * xi;
    mb = yr * yr + yi * yi;
    r.re = '0;
    r.im = '0;
    r.st = ST_OK;
    r.rel = (ma < mb) ? REL_LESS : ((ma > mb) ? REL_GREATER : REL_EQUAL);
    case (cmd)
      CMD_ADD: begin
        r.re = clamp_word(xr + yr, sat);
        r.im = clamp_word(xi + yi, sat);
      end
      CMD_SUB: begin
        r.re = clamp_word(xr - yr, sat);
        r.im = clamp_word(xi - yi, sat);
      end
      CMD_MUL: begin
        r.re = clamp_word((xr * yr - xi * yi) >>> FracBits, sat);
        r.im = clamp_word((xr * yi + xi * yr) >>> FracBits, sat);
      end
      CMD_DIV: begin
        if (mb == 0) begin
          r.st = ST_DIVZ;
        end else begin
          nre = (xr * yr + xi * yi) <<< FracBits;
          nim = (xi * yr - xr * yi) <<< FracBits;
          r.re = clamp_word(nre / mb, sat);
          r.im = clamp_word(nim / mb, sat);
        end
      end
      default: ;
    endcase
    if (sat && r.st == ST_OK) r.st = ST_SAT;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
      input logic [31:0] want);
    $display("mismatch at result %0d: %s got %h expected %h", n_checked, what, got, want);
    errors++;
  endtask

  // Send one request, with bursts and random gaps on the sender side
  task automatic send_request(input logic [2:0] cmd, input logic [31:0] ar,
      input logic [31:0] ai, input logic [31:0] br, input logic [31:0] bi);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid = 1'b1;
    in_tuser = cmd;
    in_tdata = {bi, br, ai, ar};
    do @(posedge clk); while (!in_tready);
    result_q.push_back(complex_result(cmd, ar, ai, br, bi));
    cmd_count[cmd]++;
    n_sent++;
    @(negedge clk);
  endtask

  // Hold off the sender until the pipeline has drained
  task automatic wait_drained();
    in_tvalid = 1'b0;
    burst_left = 0;
    wait (result_q.size() == 0);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic test_each_operation();
    for (int c = 0; c < 8; c++) begin
      send_request(c[2:0], 32'h0003_8000, 32'hfffe_4000, 32'h0001_0000, 32'h0002_c000);
    end
  endtask

  task automatic test_extremes();
    logic [31:0] ext[4];
    ext[0] = MAXW;
    ext[1] = MINW;
    ext[2] = 32'd0;
    ext[3] = 32'hffffffff;
    for (int i = 0; i < 4; i++) begin
      send_request(CMD_ADD, ext[i], ext[i], ext[i], ext[i]);
      send_request(CMD_SUB, ext[i], ext[3 - i], ext[3 - i], ext[i]);
      send_request(CMD_MUL, ext[i], ext[i], ext[(i + 1) % 4], ext[i]);
    end
    send_request(CMD_DIV, MAXW, MAXW, 32'd1, 32'd0);
    send_request(CMD_DIV, MINW, MINW, 32'hffffffff, 32'hffffffff);
  endtask

  task automatic test_div_by_zero();
    send_request(CMD_DIV, 32'h0001_0000, 32'h0002_0000, 32'd0, 32'd0);
    send_request(CMD_DIV, 32'd0, 32'd0, 32'd0, 32'd0);
    send_request(CMD_DIV, MINW, MAXW, 32'd0, 32'd0);
  endtask

  task automatic test_equal_magnitude();
    send_request(CMD_CMP, 32'h0003_0000, 32'h0004_0000, 32'hfffb_0000, 32'd0);
    send_request(3'd7, 32'h0001_0000, 32'd0, 32'd0, 32'hffff_0000);
  endtask

  function automatic logic [31:0] random_operand(input int kind);
    case (kind)
      0: return $urandom;
      1: return $urandom_range(0, 3) == 0 ? MINW : ($urandom_range(0, 1) ? MAXW : 32'd0);
      2: return {{14{$urandom_range(0, 1) == 1}}, 18'($urandom)};
      default: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
    endcase
  endfunction

  task automatic test_random(input int count);
    logic [2:0] cmd;
    int kind;
    for (int i = 0; i < count; i++) begin
      cmd = $urandom_range(0, 9) == 0 ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
      kind = $urandom_range(0, 9) == 0 ? 1 : $urandom_range(0, 3);
      if (kind == 1) kind = $urandom_range(0, 1) ? 1 : 0;
      if ($urandom_range(0, 30) == 0) begin
        send_request(cmd, random_operand(kind), random_operand(kind), 32'd0, 32'd0);
      end else begin
        send_request(cmd, random_operand(kind), random_operand(kind),
                     random_operand(kind), random_operand(kind));
      end
      if (i == count / 2) wait_drained();
    end
  endtask

  // Receiver stall pattern: stretches of always-ready, random, and mostly-stalled
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= $urandom_range(0, 2);
      ready_left <= $urandom_range(10, 80);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= $urandom_range(0, 1);
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    cplx_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (result_q.size() == 0) begin
        $display("unexpected result %h / %h", out_tdata, out_tuser);
        errors++;
      end else begin
        want = result_q.pop_front();
        if (out_tdata[31:0] !== want.re) report_mismatch("res_re", out_tdata[31:0], want.re);
        if (out_tdata[63:32] !== want.im) report_mismatch("res_im", out_tdata[63:32], want.im);
        if (out_tuser[1:0] !== want.rel) report_mismatch("relation", out_tuser[1:0], want.rel);
        if (out_tuser[3:2] !== want.st) report_mismatch("status", out_tuser[3:2], want.st);
      end
      n_checked++;
    end
  end

  // Watchdog on cycles with no accepted transfer on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no progress for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    for (int i = 0; i < 8; i++) cmd_count[i] = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_each_operation();
    test_extremes();
    test_div_by_zero();
    test_equal_magnitude();
    wait_drained();
    test_random(1150);
    in_tvalid = 1'b0;
    wait (result_q.size() == 0);
    repeat (LATENCY + 20) @(negedge clk);
    $display("sent %0d requests, checked %0d results", n_sent, n_checked);
    $display("add %0d sub %0d mul %0d div %0d compare-only %0d", cmd_count[0],
             cmd_count[1], cmd_count[2], cmd_count[3],
             cmd_count[4] + cmd_count[5] + cmd_count[6] + cmd_count[7]);
    if (errors == 0 && result_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
